FILE: rtl/tspc_pkg.sv
// Shared constants, types and the divider step function for the touch pressure classifier.
package tspc_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int WORD_BITS = 32;
    localparam int CFG_BITS = 16;
    localparam int PRESS_BITS = 20;
    localparam int ROUND_SHIFT = 12;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_STAGES = WORD_BITS / DIV_BITS_PER_STAGE;

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] ROUND_ADD = WORD_BITS'(2047);

    localparam logic [CFG_BITS-1:0] PLATE_RESET = CFG_BITS'(300);
    localparam logic [CFG_BITS-1:0] MAX_PRESS_RESET = CFG_BITS'(4095);

    typedef enum logic [1:0] {
        KIND_TOUCH   = 2'd0,
        KIND_IGNORED = 2'd1,
        KIND_RELEASE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_PLATE   = 2'd0,
        REG_MAX     = 2'd1,
        REG_PEN_DET = 2'd2
    } reg_idx_t;

    // Per-item information that rides along with the arithmetic.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic [SAMPLE_BITS-1:0] z1;
        logic                   rel_pen;
        logic                   zero;
    } side_t;

    // Divider state: nq holds the unconsumed dividend bits on top and the
    // quotient bits collected so far at the bottom.
    typedef struct packed {
        side_t                  side;
        logic [SAMPLE_BITS-1:0] rem;
        logic [WORD_BITS-1:0]   nq;
    } div_t;

    function automatic div_t div_step(div_t a);
        logic [SAMPLE_BITS:0] trial;
        logic [SAMPLE_BITS:0] diff;
        div_t                 r;
        trial = {a.rem, a.nq[WORD_BITS-1]};
        diff = trial - {1'b0, a.side.z1};
        r = a;
        if (trial >= {1'b0, a.side.z1}) begin
            r.rem = diff[SAMPLE_BITS-1:0];
            r.nq = {a.nq[WORD_BITS-2:0], 1'b1};
        end else begin
            r.rem = trial[SAMPLE_BITS-1:0];
            r.nq = {a.nq[WORD_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

FILE: rtl/touch_sample_pressure_classifier.sv
// Top level of the resistive touch sample pressure classifier.
// The block takes one touch sample per cycle while the output is not held and gives one
// event item per sample, in order. An item passes 11 register stages before its result
// can be taken: two multiplier stages, eight divider stages that each resolve four quotient
// bits of the 32-bit division by Z1, and one rounding and classification stage that also
// serves as the output register.
// While the output item is not taken the whole pipeline holds, so s_tready follows
// m_tready whenever a result is waiting. Configuration registers take effect at once and
// are meant to be written while no item is in flight.
module touch_sample_pressure_classifier (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // x_sample[11:0], y_sample[23:12], z1_sample[35:24], z2_sample[47:36]
    input  logic [0:0]  s_tuser,   // pen_down[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // x_pos[11:0], y_pos[23:12], pressure[43:24], zero fill[47:44]
    output logic [1:0]  m_tuser,   // event_kind[1:0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int SB = tspc_pkg::SAMPLE_BITS;
    localparam int PB = tspc_pkg::PRESS_BITS;

    logic [tspc_pkg::CFG_BITS-1:0] plate_reg;
    logic [tspc_pkg::CFG_BITS-1:0] max_press_reg;
    logic                          pen_det_reg;

    logic                adv;
    logic                front_valid;
    tspc_pkg::div_t      front_div;
    logic                div_valid;
    tspc_pkg::div_t      div_out;
    tspc_pkg::kind_t     out_kind;
    logic [SB-1:0]       out_x;
    logic [SB-1:0]       out_y;
    logic [PB-1:0]       out_press;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plate_reg <= tspc_pkg::PLATE_RESET;
            max_press_reg <= tspc_pkg::MAX_PRESS_RESET;
            pen_det_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tspc_pkg::REG_PLATE:   plate_reg <= cfg_wdata;
                tspc_pkg::REG_MAX:     max_press_reg <= cfg_wdata;
                tspc_pkg::REG_PEN_DET: pen_det_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is empty or being drained.
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    tspc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .x_sample   (s_tdata[11:0]),
        .y_sample   (s_tdata[23:12]),
        .z1_sample  (s_tdata[35:24]),
        .z2_sample  (s_tdata[47:36]),
        .pen_down   (s_tuser[0]),
        .plate_ohms (plate_reg),
        .pen_det    (pen_det_reg),
        .out_valid  (front_valid),
        .out_div    (front_div)
    );

    tspc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_div    (front_div),
        .out_valid (div_valid),
        .out_div   (div_out)
    );

    tspc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_div    (div_out),
        .max_press (max_press_reg),
        .pen_det   (pen_det_reg),
        .out_valid (m_tvalid),
        .out_kind  (out_kind),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_press (out_press)
    );

    assign m_tdata = {4'b0000, out_press, out_y, out_x};
    assign m_tuser = out_kind;

endmodule

FILE: rtl/tspc_front.sv
// Front stages: X filtering, flags, and the two wrapping multiplications.
module tspc_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [tspc_pkg::SAMPLE_BITS-1:0]   x_sample,
    input  logic [tspc_pkg::SAMPLE_BITS-1:0]   y_sample,
    input  logic [tspc_pkg::SAMPLE_BITS-1:0]   z1_sample,
    input  logic [tspc_pkg::SAMPLE_BITS-1:0]   z2_sample,
    input  logic                               pen_down,
    input  logic [tspc_pkg::CFG_BITS-1:0]      plate_ohms,
    input  logic                               pen_det,
    output logic                               out_valid,
    output tspc_pkg::div_t                     out_div
);

    localparam int SB = tspc_pkg::SAMPLE_BITS;
    localparam int WB = tspc_pkg::WORD_BITS;
    localparam int CB = tspc_pkg::CFG_BITS;

    logic [SB-1:0]    x_filt;
    logic [WB-1:0]    diff;
    logic [WB+SB-1:0] prod1_full;
    logic [WB+CB-1:0] prod2_full;
    tspc_pkg::side_t  side_in;

    tspc_pkg::side_t  side1_reg;
    logic [WB-1:0]    p1_reg;
    logic             v1_reg;
    tspc_pkg::side_t  side2_reg;
    logic [WB-1:0]    p2_reg;
    logic             v2_reg;

    assign x_filt = (x_sample == tspc_pkg::FULL_SCALE) ? '0 : x_sample;
    // The difference wraps modulo 2^32 when z2 is below z1.
    assign diff = {{(WB-SB){1'b0}}, z2_sample} - {{(WB-SB){1'b0}}, z1_sample};
    assign prod1_full = {{SB{1'b0}}, diff} * {{WB{1'b0}}, x_filt};
    assign prod2_full = {{CB{1'b0}}, p1_reg} * {{WB{1'b0}}, plate_ohms};

    always_comb begin
        side_in.x = x_filt;
        side_in.y = y_sample;
        side_in.z1 = z1_sample;
        side_in.rel_pen = pen_det & ~pen_down;
        side_in.zero = (x_filt == '0) || (z1_sample == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side1_reg <= side_in;
            p1_reg <= prod1_full[WB-1:0];
            side2_reg <= side1_reg;
            p2_reg <= prod2_full[WB-1:0];
        end
    end

    assign out_valid = v2_reg;

    always_comb begin
        out_div.side = side2_reg;
        out_div.rem = '0;
        out_div.nq = p2_reg;
    end

endmodule

FILE: rtl/tspc_div.sv
// Pipelined restoring divider of the 32-bit product by Z1, four quotient bits per stage.
module tspc_div (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           adv,
    input  logic           in_valid,
    input  tspc_pkg::div_t in_div,
    output logic           out_valid,
    output tspc_pkg::div_t out_div
);

    localparam int NS = tspc_pkg::DIV_STAGES;
    localparam int NB = tspc_pkg::DIV_BITS_PER_STAGE;

    tspc_pkg::div_t stage_reg [NS];
    logic           valid_reg [NS];
    tspc_pkg::div_t stage_in  [NS];
    logic           valid_in  [NS];

    genvar s, k;
    generate
        for (s = 0; s < NS; s++) begin : g_stage
            tspc_pkg::div_t step [NB+1];

            if (s == 0) begin : g_first
                assign stage_in[s] = in_div;
                assign valid_in[s] = in_valid;
            end else begin : g_next
                assign stage_in[s] = stage_reg[s-1];
                assign valid_in[s] = valid_reg[s-1];
            end

            assign step[0] = stage_in[s];
            for (k = 0; k < NB; k++) begin : g_step
                assign step[k+1] = tspc_pkg::div_step(step[k]);
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[s] <= 1'b0;
                end else if (adv) begin
                    valid_reg[s] <= valid_in[s];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    stage_reg[s] <= step[NB];
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NS-1];
    assign out_div = stage_reg[NS-1];

endmodule

FILE: rtl/tspc_back.sv
// Output stage: rounding, event classification and the result register.
module tspc_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              in_valid,
    input  tspc_pkg::div_t                    in_div,
    input  logic [tspc_pkg::CFG_BITS-1:0]     max_press,
    input  logic                              pen_det,
    output logic                              out_valid,
    output tspc_pkg::kind_t                   out_kind,
    output logic [tspc_pkg::SAMPLE_BITS-1:0]  out_x,
    output logic [tspc_pkg::SAMPLE_BITS-1:0]  out_y,
    output logic [tspc_pkg::PRESS_BITS-1:0]   out_press
);

    localparam int SB = tspc_pkg::SAMPLE_BITS;
    localparam int WB = tspc_pkg::WORD_BITS;
    localparam int PB = tspc_pkg::PRESS_BITS;
    localparam int CB = tspc_pkg::CFG_BITS;
    localparam int RS = tspc_pkg::ROUND_SHIFT;

    logic [WB-1:0]     rounded;
    logic [PB-1:0]     rt;
    logic              release_ev;
    tspc_pkg::kind_t   kind_next;
    logic [SB-1:0]     x_next;
    logic [SB-1:0]     y_next;
    logic [PB-1:0]     press_next;

    logic              valid_reg;
    tspc_pkg::kind_t   kind_reg;
    logic [SB-1:0]     x_reg;
    logic [SB-1:0]     y_reg;
    logic [PB-1:0]     press_reg;

    // The rounding add wraps in 32 bits, so the shifted value always fits 20 bits.
    assign rounded = in_div.nq + tspc_pkg::ROUND_ADD;
    assign rt = in_div.side.zero ? '0 : rounded[RS +: PB];
    assign release_ev = in_div.side.rel_pen || ((rt == '0) && !pen_det);

    always_comb begin
        if (release_ev) begin
            kind_next = tspc_pkg::KIND_RELEASE;
            x_next = '0;
            y_next = '0;
            press_next = '0;
        end else begin
            kind_next = (rt <= {{(PB-CB){1'b0}}, max_press}) ?
                        tspc_pkg::KIND_TOUCH : tspc_pkg::KIND_IGNORED;
            x_next = in_div.side.x;
            y_next = in_div.side.y;
            press_next = rt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            kind_reg <= kind_next;
            x_reg <= x_next;
            y_reg <= y_next;
            press_reg <= press_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind = kind_reg;
    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_press = press_reg;

    a_release_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (kind_reg == tspc_pkg::KIND_RELEASE) |->
        (x_reg == '0) && (y_reg == '0) && (press_reg == '0))
        else $error("release item carries nonzero fields");

    a_touch_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (kind_reg == tspc_pkg::KIND_TOUCH) |->
        (press_reg <= {{(PB-CB){1'b0}}, max_press}))
        else $error("touch item with pressure above the limit");

    a_ignored_above: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (kind_reg == tspc_pkg::KIND_IGNORED) |->
        (press_reg > {{(PB-CB){1'b0}}, max_press}))
        else $error("ignored item with pressure within the limit");

endmodule
